// ===== rtl/polynomial_easing_curve_assert.svh =====
// Assertion helpers for the easing curve pipeline.
`ifndef POLYNOMIAL_EASING_CURVE_ASSERT_SVH
`define POLYNOMIAL_EASING_CURVE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define PEC_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("easing curve assertion failed");
// Next-cycle implication.
`define PEC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("easing curve assertion failed");
`else
`define PEC_ASSERT_NOW(name, clk, rst, ante, cons)
`define PEC_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/pec_pkg.sv =====
`timescale 1ns / 1ps

package pec_pkg;

   // Fixed field widths and defaults
   localparam int FRAC_BITS_DEF = 15;
   localparam int PROGRESS_W    = 16;
   localparam int CURVE_W       = 3;
   localparam int DIR_W         = 2;
   localparam int OVERSHOOT_W   = 16;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 16;

   // Overshoot after reset, Q3.13 (about 1.70158)
   localparam logic [OVERSHOOT_W-1:0] OVERSHOOT_RST = 16'd13939;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CURVE_KIND = 2'd0,
      CSR_DIRECTION  = 2'd1,
      CSR_OVERSHOOT  = 2'd2
   } csr_index_type;

   // Curve kinds; the two unused codes fall back to quad
   typedef enum logic [CURVE_W-1:0] {
      CURVE_QUAD   = 3'd0,
      CURVE_CUBIC  = 3'd1,
      CURVE_QUART  = 3'd2,
      CURVE_QUINT  = 3'd3,
      CURVE_BACK   = 3'd4,
      CURVE_BOUNCE = 3'd5
   } curve_kind_type;

   // Directions; the unused code falls back to ease in
   typedef enum logic [DIR_W-1:0] {
      DIR_IN    = 2'd0,
      DIR_OUT   = 2'd1,
      DIR_INOUT = 2'd2
   } direction_type;

   // How the ease-in value is folded into the result
   typedef enum logic [1:0] {
      MODE_IN    = 2'd0,
      MODE_OUT   = 2'd1,
      MODE_IO_LO = 2'd2,
      MODE_IO_HI = 2'd3
   } mode_type;

endpackage

// ===== rtl/polynomial_easing_curve.sv =====
`timescale 1ns / 1ps
// Channel   | Ports                                        | Flow
// ----------+----------------------------------------------+-----------------------------
// request   | start, busy, req_progress                    | in, taken when start & !busy
// response  | rsp_strobe, rsp_eased_value, rsp_clipped     | out, one-cycle strobe
// config    | csr_wr_en, csr_index, csr_wdata              | in, write on csr_wr_en
//
// One transfer per cycle; busy stays low, the pipeline never stalls.
// The pipeline has four stages plus the output register; the
// three chained multiplies of the quint curve set the depth.
// Reset is synchronous, active high: it clears the stage valid bits and
// restores the configuration defaults.
// The receiver cannot stall: each result shows for exactly one cycle.
`include "polynomial_easing_curve_assert.svh"

module polynomial_easing_curve
   import pec_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [PROGRESS_W-1:0]         req_progress,
   output logic                          rsp_strobe,
   output logic signed [FRAC_BITS+1:0]   rsp_eased_value,
   output logic                          rsp_clipped,
   input  logic                          csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata
);

   localparam int F    = FRAC_BITS;
   localparam int XW   = F + 1;
   localparam int SW   = F + 4;
   localparam int EYW  = F + 5;
   localparam int DW   = F + 6;
   localparam int DAW  = F + 3;
   localparam int BW   = F + 6;
   localparam int BKW  = XW + 1 + BW;
   localparam int EW   = F + 6;
   localparam int VW   = F + 7;
   localparam int OUTW = F + 2;
   localparam int TW   = (XW > PROGRESS_W) ? XW : PROGRESS_W;

   localparam longint unsigned ONE_L  = 64'd1 << F;
   localparam longint unsigned HALF_L = 64'd1 << (F - 1);
   localparam longint unsigned S_RST  =
      ((longint'(OVERSHOOT_RST) << F) + 64'd4096) >> 13;
   localparam longint unsigned S2_RST =
      (((longint'(OVERSHOOT_RST) * 64'd61) << F) + 64'd163840) / 64'd327680;

   localparam logic [XW-1:0]  ONE_X = XW'(ONE_L);
   localparam logic [EYW-1:0] SEG1_LIM = EYW'(ONE_L * 4);
   localparam logic [EYW-1:0] SEG2_LIM = EYW'(ONE_L * 8);
   localparam logic [EYW-1:0] SEG3_LIM = EYW'(ONE_L * 10);
   localparam logic [EYW-1:0] SEG1_K   = EYW'(ONE_L * 6);
   localparam logic [EYW-1:0] SEG2_K   = EYW'(ONE_L * 9);
   localparam logic [EYW-1:0] SEG3_K   = EYW'((ONE_L * 21) / 2);
   localparam logic [F-1:0]   SEG1_OFF = F'((ONE_L * 3) / 4);
   localparam logic [F-1:0]   SEG2_OFF = F'((ONE_L * 15) / 16);
   localparam logic [F-1:0]   SEG3_OFF = F'((ONE_L * 63) / 64);
   localparam logic signed [VW-1:0]   OUT_MAX_V = VW'(2 * ONE_L - 1);
   localparam logic signed [VW-1:0]   OUT_MIN_V = -OUT_MAX_V - VW'(1);
   localparam logic signed [OUTW-1:0] OUT_MAX_O = OUTW'(OUT_MAX_V);
   localparam logic signed [OUTW-1:0] OUT_MIN_O = OUTW'(OUT_MIN_V);

   // Configuration
   logic [CURVE_W-1:0] kind_ff, kind_in;
   logic [DIR_W-1:0]   dir_ff, dir_in;
   logic [SW-1:0]      s_ff, s_in;
   logic [SW-1:0]      s2_ff, s2_in;
   logic [SW-1:0]      s_sel;

   logic [F+16:0]      ovs_sum;
   logic [21:0]        ov61;
   logic [F+22:0]      ov61_sum;
   logic [31:0]        ov_m;
   logic [63:0]        ov_q;

   // Stage 1
   logic               vld1_ff, vld1_in;
   logic [XW-1:0]      x1_ff, x1_in;
   mode_type           mode1_ff, mode1_in;
   logic [TW-1:0]      t_ext;
   logic [XW-1:0]      t;
   logic [XW-1:0]      omt;

   // Stage 2
   logic               vld2_ff;
   logic [2*XW-1:0]    sq2_ff, sq2_in;
   logic [SW+XW-1:0]   sa2_ff, sa2_in;
   logic [DAW-1:0]     dabs2_ff, dabs2_in;
   logic [F-1:0]       off2_ff, off2_in;
   logic [XW-1:0]      x2c_ff;
   mode_type           mode2_ff;
   logic [SW-1:0]      sp1;
   logic [XW-1:0]      y;
   logic [EYW-1:0]     ey;
   logic [EYW-1:0]     k_sel;
   logic signed [DW-1:0] d;

   // Stage 3
   logic               vld3_ff;
   logic [XW-1:0]      xsq3_ff, xsq3_in;
   logic [2*XW-1:0]    cu3_ff, cu3_in;
   logic [2*XW-1:0]    qa3_ff, qa3_in;
   logic signed [BKW-1:0] bk3_ff, bk3_in;
   logic [2*DAW-1:0]   bo3_ff, bo3_in;
   logic [F-1:0]       off3_ff;
   logic [XW-1:0]      x3_ff;
   mode_type           mode3_ff;
   logic [2*XW:0]      sq_sum;
   logic [SW+XW:0]     sa_sum;
   logic [F+4:0]       a_val;
   logic signed [BW-1:0] b_val;

   // Stage 4
   logic               vld4_ff;
   logic signed [EW-1:0] e4_ff, e4_in;
   logic [2*XW-1:0]    qn4_ff, qn4_in;
   mode_type           mode4_ff;
   logic [2*XW:0]      cu_sum;
   logic [2*XW:0]      qa_sum;
   logic [XW-1:0]      cubic_v;
   logic [XW-1:0]      quart_v;
   logic [BKW-1:0]     bk_mag;
   logic [BKW:0]       bk_sum;
   logic [F+4:0]       bk_r;
   logic signed [EW-1:0] back_v;
   logic [2*DAW:0]     bo_sum;
   logic [XW-1:0]      bq;
   logic [XW-1:0]      bnc;
   logic [XW-1:0]      bounce_v;

   // Output stage
   logic               rsp_strobe_ff;
   logic signed [OUTW-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_clipped_ff, rsp_clipped_in;
   logic [2*XW:0]      qn_sum;
   logic signed [EW-1:0] e_fin;
   logic [EW-1:0]      e_mag;
   logic [EW-1:0]      h_mag;
   logic signed [EW-1:0] e_half;
   logic signed [VW-1:0] v;

   // The pipeline takes a transfer every cycle
   assign busy = 1'b0;

   // Derive both overshoot scalings at write time
   always_comb begin
      ovs_sum  = {1'b0, csr_wdata, {F{1'b0}}} + (F+17)'(4096);
      ov61     = 22'(csr_wdata) * 22'd61;
      ov61_sum = (F+23)'({ov61, {F{1'b0}}}) + (F+23)'(163840);
      ov_m     = 32'(ov61_sum >> 16);
      ov_q     = 64'(ov_m) * 64'hCCCC_CCCD;
   end

   // Decode configuration writes
   always_comb begin
      kind_in = kind_ff;
      dir_in  = dir_ff;
      s_in    = s_ff;
      s2_in   = s2_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_CURVE_KIND: kind_in = csr_wdata[CURVE_W-1:0];
            CSR_DIRECTION:  dir_in  = csr_wdata[DIR_W-1:0];
            CSR_OVERSHOOT: begin
               s_in  = SW'(ovs_sum >> 13);
               s2_in = SW'(ov_q >> 34);
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= CURVE_QUAD;
         dir_ff  <= DIR_IN;
         s_ff    <= SW'(S_RST);
         s2_ff   <= SW'(S2_RST);
      end else begin
         kind_ff <= kind_in;
         dir_ff  <= dir_in;
         s_ff    <= s_in;
         s2_ff   <= s2_in;
      end
   end

   assign s_sel = (dir_ff == DIR_INOUT) ? s2_ff : s_ff;

   // Stage 1: clamp progress and fold the direction into the curve argument
   always_comb begin
      t_ext = TW'(req_progress);
      if (t_ext > TW'(ONE_X)) begin
         t_ext = TW'(ONE_X);
      end
      t   = XW'(t_ext);
      omt = ONE_X - t;
      case (dir_ff)
         DIR_OUT: begin
            x1_in    = omt;
            mode1_in = MODE_OUT;
         end
         DIR_INOUT: begin
            if (!t[F] && !t[F-1]) begin
               x1_in    = {t[F-1:0], 1'b0};
               mode1_in = MODE_IO_LO;
            end else begin
               x1_in    = {omt[F-1:0], 1'b0};
               mode1_in = MODE_IO_HI;
            end
         end
         default: begin
            x1_in    = t;
            mode1_in = MODE_IN;
         end
      endcase
      vld1_in = start && !busy;
   end

   // Stage 2: square, back slope product, bounce segment select
   always_comb begin
      sq2_in = (2*XW)'(x1_ff) * (2*XW)'(x1_ff);
      sp1    = s_sel + SW'(ONE_X);
      sa2_in = (SW+XW)'(sp1) * (SW+XW)'(x1_ff);
      y      = ONE_X - x1_ff;
      ey     = EYW'(y) * EYW'(4'd11);
      if (ey < SEG1_LIM) begin
         k_sel   = '0;
         off2_in = '0;
      end else if (ey < SEG2_LIM) begin
         k_sel   = SEG1_K;
         off2_in = SEG1_OFF;
      end else if (ey < SEG3_LIM) begin
         k_sel   = SEG2_K;
         off2_in = SEG2_OFF;
      end else begin
         k_sel   = SEG3_K;
         off2_in = SEG3_OFF;
      end
      d        = $signed(DW'(ey)) - $signed(DW'(k_sel));
      dabs2_in = d[DW-1] ? DAW'(-d) : DAW'(d);
   end

   // Stage 3: round the first products, start the second ones
   always_comb begin
      sq_sum  = (2*XW+1)'(sq2_ff) + (2*XW+1)'(HALF_L);
      xsq3_in = sq_sum[2*F:F];
      sa_sum  = (SW+XW+1)'(sa2_ff) + (SW+XW+1)'(HALF_L);
      a_val   = sa_sum[2*F+4:F];
      b_val   = $signed(BW'(a_val)) - $signed(BW'(s_sel));
      cu3_in  = (2*XW)'(xsq3_in) * (2*XW)'(x2c_ff);
      qa3_in  = (2*XW)'(xsq3_in) * (2*XW)'(xsq3_in);
      bk3_in  = $signed(BKW'({1'b0, xsq3_in})) * $signed(BKW'(b_val));
      bo3_in  = (2*DAW)'(dabs2_ff) * (2*DAW)'(dabs2_ff);
   end

   // Stage 4: round the curves, pick one, start the quint product
   always_comb begin
      cu_sum   = (2*XW+1)'(cu3_ff) + (2*XW+1)'(HALF_L);
      cubic_v  = cu_sum[2*F:F];
      qa_sum   = (2*XW+1)'(qa3_ff) + (2*XW+1)'(HALF_L);
      quart_v  = qa_sum[2*F:F];
      bk_mag   = bk3_ff[BKW-1] ? BKW'(-bk3_ff) : BKW'(bk3_ff);
      bk_sum   = (BKW+1)'(bk_mag) + (BKW+1)'(HALF_L);
      bk_r     = bk_sum[2*F+4:F];
      back_v   = bk3_ff[BKW-1] ? -$signed(EW'(bk_r)) : $signed(EW'(bk_r));
      bo_sum   = (2*DAW+1)'(bo3_ff) + (2*DAW+1)'(ONE_L * 8);
      bq       = bo_sum[2*F+4:F+4];
      bnc      = bq + XW'(off3_ff);
      bounce_v = ONE_X - bnc;
      qn4_in   = (2*XW)'(quart_v) * (2*XW)'(x3_ff);
      case (kind_ff)
         CURVE_CUBIC:  e4_in = $signed(EW'(cubic_v));
         CURVE_QUART:  e4_in = $signed(EW'(quart_v));
         CURVE_BACK:   e4_in = back_v;
         CURVE_BOUNCE: e4_in = $signed(EW'(bounce_v));
         default:      e4_in = $signed(EW'(xsq3_ff));
      endcase
   end

   // Output stage: finish quint, fold by direction, saturate
   always_comb begin
      qn_sum = (2*XW+1)'(qn4_ff) + (2*XW+1)'(HALF_L);
      e_fin  = (kind_ff == CURVE_QUINT) ? $signed(EW'(qn_sum[2*F:F])) : e4_ff;
      e_mag  = e_fin[EW-1] ? EW'(-e_fin) : EW'(e_fin);
      h_mag  = (e_mag + EW'(1)) >> 1;
      e_half = e_fin[EW-1] ? -$signed(h_mag) : $signed(h_mag);
      case (mode4_ff)
         MODE_OUT:   v = $signed(VW'(ONE_X)) - VW'(e_fin);
         MODE_IO_LO: v = VW'(e_half);
         MODE_IO_HI: v = $signed(VW'(ONE_X)) - VW'(e_half);
         default:    v = VW'(e_fin);
      endcase
      if (v > OUT_MAX_V) begin
         rsp_value_in   = OUT_MAX_O;
         rsp_clipped_in = 1'b1;
      end else if (v < OUT_MIN_V) begin
         rsp_value_in   = OUT_MIN_O;
         rsp_clipped_in = 1'b1;
      end else begin
         rsp_value_in   = OUTW'(v);
         rsp_clipped_in = 1'b0;
      end
   end

   // Advance the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff       <= 1'b0;
         vld2_ff       <= 1'b0;
         vld3_ff       <= 1'b0;
         vld4_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         vld1_ff       <= vld1_in;
         vld2_ff       <= vld1_ff;
         vld3_ff       <= vld2_ff;
         vld4_ff       <= vld3_ff;
         rsp_strobe_ff <= vld4_ff;
      end
   end

   // Advance the payload
   always_ff @(posedge clock) begin
      x1_ff          <= x1_in;
      mode1_ff       <= mode1_in;
      sq2_ff         <= sq2_in;
      sa2_ff         <= sa2_in;
      dabs2_ff       <= dabs2_in;
      off2_ff        <= off2_in;
      x2c_ff         <= x1_ff;
      mode2_ff       <= mode1_ff;
      xsq3_ff        <= xsq3_in;
      cu3_ff         <= cu3_in;
      qa3_ff         <= qa3_in;
      bk3_ff         <= bk3_in;
      bo3_ff         <= bo3_in;
      off3_ff        <= off2_ff;
      x3_ff          <= x2c_ff;
      mode3_ff       <= mode2_ff;
      e4_ff          <= e4_in;
      qn4_ff         <= qn4_in;
      mode4_ff       <= mode3_ff;
      rsp_value_ff   <= rsp_value_in;
      rsp_clipped_ff <= rsp_clipped_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_eased_value = rsp_value_ff;
   assign rsp_clipped     = rsp_clipped_ff;

   `PEC_ASSERT_NEXT(a_accept_enters, clock, reset, start && !busy, vld1_ff)
   `PEC_ASSERT_NEXT(a_last_stage_strobes, clock, reset, vld4_ff, rsp_strobe)
   `PEC_ASSERT_NEXT(a_no_spurious_strobe, clock, reset, !vld4_ff, !rsp_strobe)
   `PEC_ASSERT_NOW(a_clip_at_limit, clock, reset, rsp_strobe && rsp_clipped, rsp_eased_value == OUT_MAX_O || rsp_eased_value == OUT_MIN_O)

endmodule
